@@ sv/i2c_master_register_access_core_macros.svh @@
// Assertion macros for the I2C register access core.
// Used by i2c_master_register_access_core; no other dependencies.
`ifndef I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define I2C_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define I2C_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2C_ASSERT(lbl, clk, rst, prop, msg)
`define I2C_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ sv/i2c_mra_pkg.sv @@
// Shared types and constants for the I2C register access core.
// No dependencies.
`timescale 1ns / 1ps

package i2c_mra_pkg;

  localparam int MAX_BYTES_DEFAULT = 8;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_LOAD  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_PROBE = 3'd4;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_PROBE = 2'd2;

  localparam logic [1:0] STG_ADDR  = 2'd0;
  localparam logic [1:0] STG_SUB   = 2'd1;
  localparam logic [1:0] STG_DATA  = 2'd2;
  localparam logic [1:0] STG_RADDR = 2'd3;

  localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_PHASE_TICKS   = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd2;
  localparam logic [1:0] CFG_ACK_RECOVERY  = 2'd3;

  localparam logic [6:0]  SLAVE_ADDRESS_RST = 7'd19;
  localparam logic [15:0] PHASE_TICKS_RST   = 16'd10;
  localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd1000;
  localparam logic [15:0] ACK_RECOVERY_RST  = 16'd100;

  typedef struct packed {
    logic [2:0] req_type;
    logic       sda_in;
    logic [7:0] reg_addr;
    logic [3:0] byte_count;
    logic [7:0] wr_byte;
  } req_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       busy_res;
    logic       done_res;
    logic       status;
    logic       rejected;
  } res_word_t;

endpackage

@@ sv/i2c_master_register_access_core.sv @@
// Each accepted word's result is registered; one word per cycle while req_stall is low.
// Each tick word advances the bus sequencer by at most one step (two after an ACK recovery).
// A two-entry output stage (result register plus skid) keeps req_stall low while one result waits.
// Reset (rst, synchronous): sequencer idle, SCL high, SDA released, registers to defaults.
// The write buffer is not cleared; its entries are undefined until loaded.
`timescale 1ns / 1ps
`include "i2c_master_register_access_core_macros.svh"

module i2c_master_register_access_core
  import i2c_mra_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_word_t   req_word,
  output logic        res_valid,
  input  logic        res_stall,
  output res_word_t   res_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW   = $clog2(MAX_BYTES + 1);
  localparam int AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNTW = (CW > 4) ? CW : 4;

  localparam logic [4:0] S_IDLE        = 5'd0;
  localparam logic [4:0] S_ST_SDA_HI   = 5'd1;
  localparam logic [4:0] S_ST_SCL_HI   = 5'd2;
  localparam logic [4:0] S_ST_SDA_LO   = 5'd3;
  localparam logic [4:0] S_ST_SCL_LO   = 5'd4;
  localparam logic [4:0] S_WB_DATA     = 5'd5;
  localparam logic [4:0] S_WB_SCL_HI   = 5'd6;
  localparam logic [4:0] S_WB_SCL_LO   = 5'd7;
  localparam logic [4:0] S_ACK_SCL_HI  = 5'd8;
  localparam logic [4:0] S_ACK_WAIT    = 5'd9;
  localparam logic [4:0] S_ACK_RECOVER = 5'd10;
  localparam logic [4:0] S_RB_SCL_HI   = 5'd11;
  localparam logic [4:0] S_RB_SAMPLE   = 5'd12;
  localparam logic [4:0] S_MA_DATA     = 5'd13;
  localparam logic [4:0] S_MA_SCL_HI   = 5'd14;
  localparam logic [4:0] S_MA_SCL_LO   = 5'd15;
  localparam logic [4:0] S_SP_SDA_LO   = 5'd16;
  localparam logic [4:0] S_SP_SCL_HI   = 5'd17;
  localparam logic [4:0] S_SP_SCL_HI2  = 5'd18;
  localparam logic [4:0] S_SP_SDA_HI   = 5'd19;
  localparam logic [4:0] S_FINISH      = 5'd20;

  // configuration
  logic [6:0]  slave_address;
  logic [15:0] phase_ticks;
  logic [15:0] ack_timeout_ticks;
  logic [15:0] ack_recovery_ticks;

  // sequencer state
  logic [4:0]    step, step_next;
  logic [1:0]    op_kind, op_kind_next;
  logic [1:0]    stage, stage_next;
  logic [2:0]    bit_index, bit_index_next;
  logic [CW-1:0] byte_index, byte_index_next;
  logic [15:0]   phase_counter, phase_counter_next;
  logic [15:0]   timeout_counter, timeout_counter_next;
  logic [7:0]    shift_reg, shift_reg_next;
  logic [7:0]    target_reg, target_reg_next;
  logic [CW-1:0] xfer_length, xfer_length_next;
  logic [CW-1:0] buffer_fill, buffer_fill_next;
  logic          scl_reg, scl_reg_next;
  logic          sda_reg, sda_reg_next;
  logic          drive_reg, drive_reg_next;

  // write buffer
  logic [7:0]    write_buffer [MAX_BYTES];
  logic [7:0]    buf_rdata;
  logic [AW-1:0] buf_raddr;
  logic          buf_we;

  // output stage
  logic      skid_valid;
  res_word_t skid_word;
  res_word_t result;
  logic      accept;
  logic      res_fire;

  logic [15:0]   hold_val;
  logic [15:0]   timeout_lim;
  logic [CW-1:0] byte_inc;
  logic [CW-1:0] count_clamped;
  logic          done_flag;
  logic          fail_flag;
  logic          rd_flag;
  logic          rej_flag;
  logic [7:0]    rd_byte;

  assign cfg_ready = 1'b1;
  assign req_stall = skid_valid;
  assign accept    = req_valid && !skid_valid;
  assign res_fire  = res_valid && !res_stall;

  assign hold_val    = (phase_ticks == 16'd0) ? 16'd0 : phase_ticks - 16'd1;
  assign timeout_lim = (ack_timeout_ticks == 16'd0) ? 16'd1 : ack_timeout_ticks;
  assign byte_inc    = byte_index + CW'(1);
  assign count_clamped = (CNTW'(req_word.byte_count) > CNTW'(MAX_BYTES)) ?
                         CW'(MAX_BYTES) : CW'(req_word.byte_count);
  assign buf_raddr   = (stage == STG_SUB) ? AW'(0) : AW'(byte_inc);

  always_comb begin
    step_next            = step;
    op_kind_next         = op_kind;
    stage_next           = stage;
    bit_index_next       = bit_index;
    byte_index_next      = byte_index;
    phase_counter_next   = phase_counter;
    timeout_counter_next = timeout_counter;
    shift_reg_next       = shift_reg;
    target_reg_next      = target_reg;
    xfer_length_next     = xfer_length;
    buffer_fill_next     = buffer_fill;
    scl_reg_next         = scl_reg;
    sda_reg_next         = sda_reg;
    drive_reg_next       = drive_reg;
    buf_we               = 1'b0;
    done_flag            = 1'b0;
    fail_flag            = 1'b0;
    rd_flag              = 1'b0;
    rej_flag             = 1'b0;
    rd_byte              = 8'd0;

    if (req_word.req_type == REQ_TICK) begin
      if (step != S_IDLE) begin
        if (phase_counter != 16'd0) begin
          phase_counter_next = phase_counter - 16'd1;
        end else begin
          unique case (step)
            S_ST_SDA_HI: begin
              drive_reg_next = 1'b1; sda_reg_next = 1'b1;
              phase_counter_next = hold_val; step_next = S_ST_SCL_HI;
            end
            S_ST_SCL_HI: begin
              scl_reg_next = 1'b1; phase_counter_next = hold_val; step_next = S_ST_SDA_LO;
            end
            S_ST_SDA_LO: begin
              drive_reg_next = 1'b1; sda_reg_next = 1'b0;
              phase_counter_next = hold_val; step_next = S_ST_SCL_LO;
            end
            S_ST_SCL_LO: begin
              scl_reg_next = 1'b0; phase_counter_next = hold_val;
              shift_reg_next = {slave_address, stage == STG_RADDR};
              bit_index_next = 3'd0; step_next = S_WB_DATA;
            end
            S_WB_DATA: begin
              drive_reg_next = 1'b1; sda_reg_next = shift_reg[7];
              phase_counter_next = hold_val; step_next = S_WB_SCL_HI;
            end
            S_WB_SCL_HI: begin
              scl_reg_next = 1'b1; phase_counter_next = hold_val; step_next = S_WB_SCL_LO;
            end
            S_WB_SCL_LO: begin
              scl_reg_next = 1'b0; phase_counter_next = hold_val;
              shift_reg_next = {shift_reg[6:0], 1'b0};
              bit_index_next = bit_index + 3'd1;
              step_next = (bit_index == 3'd7) ? S_ACK_SCL_HI : S_WB_DATA;
            end
            S_ACK_SCL_HI: begin
              drive_reg_next = 1'b0; sda_reg_next = 1'b1; scl_reg_next = 1'b1;
              phase_counter_next = hold_val; timeout_counter_next = 16'd0;
              step_next = S_ACK_WAIT;
            end
            S_ACK_WAIT: begin
              if (!req_word.sda_in) begin
                scl_reg_next = 1'b0; phase_counter_next = hold_val;
                timeout_counter_next = 16'd0; step_next = S_ACK_RECOVER;
              end else begin
                timeout_counter_next = (timeout_counter == 16'hFFFF) ?
                                       timeout_counter : timeout_counter + 16'd1;
                if (timeout_counter_next >= timeout_lim) begin
                  done_flag = 1'b1; fail_flag = 1'b1; step_next = S_IDLE;
                end
              end
            end
            S_ACK_RECOVER: begin
              if (timeout_counter < ack_recovery_ticks) begin
                timeout_counter_next = timeout_counter + 16'd1;
              end else begin
                timeout_counter_next = 16'd0;
                // pick the next bus action, then take it on this same tick
                unique case (stage)
                  STG_ADDR: begin
                    if (op_kind == KIND_PROBE) begin
                      step_next = S_SP_SDA_LO;
                    end else begin
                      stage_next = STG_SUB; shift_reg_next = target_reg;
                      bit_index_next = 3'd0; step_next = S_WB_DATA;
                    end
                  end
                  STG_SUB: begin
                    if (op_kind == KIND_READ) begin
                      stage_next = STG_RADDR; step_next = S_ST_SDA_HI;
                    end else begin
                      byte_index_next = '0;
                      if (xfer_length == '0) begin
                        step_next = S_SP_SDA_LO;
                      end else begin
                        stage_next = STG_DATA; shift_reg_next = buf_rdata;
                        bit_index_next = 3'd0; step_next = S_WB_DATA;
                      end
                    end
                  end
                  STG_DATA: begin
                    byte_index_next = byte_inc;
                    if (byte_inc >= xfer_length) begin
                      step_next = S_SP_SDA_LO;
                    end else begin
                      shift_reg_next = buf_rdata; bit_index_next = 3'd0;
                      step_next = S_WB_DATA;
                    end
                  end
                  default: begin
                    if (xfer_length == '0) begin
                      step_next = S_SP_SDA_LO;
                    end else begin
                      byte_index_next = '0; bit_index_next = 3'd0;
                      shift_reg_next = 8'd0; step_next = S_RB_SCL_HI;
                    end
                  end
                endcase
                phase_counter_next = hold_val;
                priority case (step_next)
                  S_WB_DATA: begin
                    drive_reg_next = 1'b1; sda_reg_next = shift_reg_next[7];
                    step_next = S_WB_SCL_HI;
                  end
                  S_ST_SDA_HI: begin
                    drive_reg_next = 1'b1; sda_reg_next = 1'b1; step_next = S_ST_SCL_HI;
                  end
                  S_SP_SDA_LO: begin
                    drive_reg_next = 1'b1; sda_reg_next = 1'b0; step_next = S_SP_SCL_HI;
                  end
                  default: begin
                    scl_reg_next = 1'b1; step_next = S_RB_SAMPLE;
                  end
                endcase
              end
            end
            S_RB_SCL_HI: begin
              scl_reg_next = 1'b1; phase_counter_next = hold_val; step_next = S_RB_SAMPLE;
            end
            S_RB_SAMPLE: begin
              drive_reg_next = 1'b0; sda_reg_next = 1'b1;
              shift_reg_next = {shift_reg[6:0], req_word.sda_in};
              scl_reg_next = 1'b0; phase_counter_next = hold_val;
              bit_index_next = bit_index + 3'd1;
              if (bit_index == 3'd7) begin
                rd_flag = 1'b1; rd_byte = shift_reg_next; step_next = S_MA_DATA;
              end else begin
                step_next = S_RB_SCL_HI;
              end
            end
            S_MA_DATA: begin
              drive_reg_next = 1'b1; sda_reg_next = (byte_inc >= xfer_length);
              phase_counter_next = hold_val; step_next = S_MA_SCL_HI;
            end
            S_MA_SCL_HI: begin
              scl_reg_next = 1'b1; phase_counter_next = hold_val; step_next = S_MA_SCL_LO;
            end
            S_MA_SCL_LO: begin
              scl_reg_next = 1'b0; phase_counter_next = hold_val;
              byte_index_next = byte_inc; shift_reg_next = 8'd0;
              step_next = (byte_inc >= xfer_length) ? S_SP_SDA_LO : S_RB_SCL_HI;
            end
            S_SP_SDA_LO: begin
              drive_reg_next = 1'b1; sda_reg_next = 1'b0;
              phase_counter_next = hold_val; step_next = S_SP_SCL_HI;
            end
            S_SP_SCL_HI: begin
              scl_reg_next = 1'b1; phase_counter_next = hold_val; step_next = S_SP_SCL_HI2;
            end
            S_SP_SCL_HI2: begin
              scl_reg_next = 1'b1; phase_counter_next = hold_val; step_next = S_SP_SDA_HI;
            end
            S_SP_SDA_HI: begin
              drive_reg_next = 1'b1; sda_reg_next = 1'b1;
              phase_counter_next = hold_val; step_next = S_FINISH;
            end
            S_FINISH: begin
              done_flag = 1'b1; step_next = S_IDLE;
            end
            default: begin
              step_next = S_IDLE;
            end
          endcase
        end
      end
    end else if (req_word.req_type == REQ_LOAD || req_word.req_type == REQ_WRITE ||
                 req_word.req_type == REQ_READ || req_word.req_type == REQ_PROBE) begin
      if (step != S_IDLE) begin
        rej_flag = 1'b1;
      end else if (req_word.req_type == REQ_LOAD) begin
        if (buffer_fill >= CW'(MAX_BYTES)) begin
          rej_flag = 1'b1;
        end else begin
          buf_we = 1'b1;
          buffer_fill_next = buffer_fill + CW'(1);
        end
      end else begin
        op_kind_next = (req_word.req_type == REQ_WRITE) ? KIND_WRITE :
                       (req_word.req_type == REQ_READ) ? KIND_READ : KIND_PROBE;
        target_reg_next = req_word.reg_addr;
        xfer_length_next = count_clamped;
        if (req_word.req_type == REQ_WRITE) buffer_fill_next = '0;
        stage_next = STG_ADDR;
        bit_index_next = 3'd0;
        byte_index_next = '0;
        phase_counter_next = 16'd0;
        timeout_counter_next = 16'd0;
        shift_reg_next = 8'd0;
        step_next = S_ST_SDA_HI;
      end
    end

    result.scl_level = scl_reg_next;
    result.sda_level = drive_reg_next ? sda_reg_next : 1'b1;
    result.sda_drive = drive_reg_next;
    result.rd_data   = rd_byte;
    result.rd_valid  = rd_flag;
    result.busy_res  = (step_next != S_IDLE);
    result.done_res  = done_flag;
    result.status    = done_flag && fail_flag;
    result.rejected  = rej_flag;
  end

  // write buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && buf_we) begin
      write_buffer[AW'(buffer_fill)] <= req_word.wr_byte;
    end
    buf_rdata <= write_buffer[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address      <= SLAVE_ADDRESS_RST;
      phase_ticks        <= PHASE_TICKS_RST;
      ack_timeout_ticks  <= ACK_TIMEOUT_RST;
      ack_recovery_ticks <= ACK_RECOVERY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS: slave_address      <= cfg_data[6:0];
        CFG_PHASE_TICKS:   phase_ticks        <= cfg_data;
        CFG_ACK_TIMEOUT:   ack_timeout_ticks  <= cfg_data;
        CFG_ACK_RECOVERY:  ack_recovery_ticks <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= S_IDLE;
      op_kind         <= KIND_WRITE;
      stage           <= STG_ADDR;
      bit_index       <= 3'd0;
      byte_index      <= '0;
      phase_counter   <= 16'd0;
      timeout_counter <= 16'd0;
      shift_reg       <= 8'd0;
      target_reg      <= 8'd0;
      xfer_length     <= '0;
      buffer_fill     <= '0;
      scl_reg         <= 1'b1;
      sda_reg         <= 1'b1;
      drive_reg       <= 1'b0;
    end else if (accept) begin
      step            <= step_next;
      op_kind         <= op_kind_next;
      stage           <= stage_next;
      bit_index       <= bit_index_next;
      byte_index      <= byte_index_next;
      phase_counter   <= phase_counter_next;
      timeout_counter <= timeout_counter_next;
      shift_reg       <= shift_reg_next;
      target_reg      <= target_reg_next;
      xfer_length     <= xfer_length_next;
      buffer_fill     <= buffer_fill_next;
      scl_reg         <= scl_reg_next;
      sda_reg         <= sda_reg_next;
      drive_reg       <= drive_reg_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (res_valid && !res_fire) begin
        skid_valid <= 1'b1;
      end else begin
        res_valid <= 1'b1;
      end
    end else if (res_fire) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (res_fire) res_word <= skid_word;
    end else if (accept) begin
      if (res_valid && !res_fire) begin
        skid_word <= result;
      end else begin
        res_word <= result;
      end
    end
  end

  `I2C_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> res_valid, "skid full with empty output register")
  `I2C_ASSERT(a_idle_bus_levels, clk, rst, (step == S_IDLE) |-> (scl_reg && sda_reg), "idle bus not high")
  `I2C_ASSERT(a_done_not_busy, clk, rst, (res_valid && res_word.done_res) |-> !res_word.busy_res, "done while busy")
  `I2C_ASSERT(a_status_with_done, clk, rst, (res_valid && res_word.status) |-> res_word.done_res, "status without done")

endmodule
